[hw/rtl/cct_pkg.sv]
// shared types and constants of the coalescing chunk table
`default_nettype none
package cct_pkg;
   localparam logic [2:0] OP_GET   = 3'd0;
   localparam logic [2:0] OP_UNGET = 3'd1;
   localparam logic [2:0] OP_PUT   = 3'd2;
   localparam logic [2:0] OP_QUERY = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;
   localparam logic [30:0] MAX_LEN = 31'h7fffffff;

   typedef struct packed {
      logic [2:0]  opcode;
      logic        list_select;
      logic [31:0] chunk_start;
      logic [30:0] chunk_bytes;
      logic [30:0] request_bytes;
   } req_type;

   typedef struct packed {
      logic [31:0] got_start;
      logic [30:0] got_bytes;
      logic [31:0] list_bytes;
      logic        table_full;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_TAKE, ST_TAKE_SCAN, ST_MERGE_SCAN, ST_MERGE_WR,
      ST_BLANK_SCAN, ST_CLEAR, ST_DONE
   } state_type;
endpackage
`default_nettype wire

[hw/rtl/cct_ram.sv]
// generic single port ram with registered read
`default_nettype none
module cct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

[hw/rtl/coalescing_chunk_table.sv]
// coalescing chunk table top level with scan sequencer
// get takes from the cursor slot, then scans for the next; clear steps over all SLOTS slots whatever n is
// put/unget: the merge scan visits each slot and reads back a slot of the list; a free-list merge
//   chains take/give-back passes, and placing scans for a blank slot
// throughput: one command at a time, busy is high from start until the strobe
// reset clears valid/tag bits, cursors and totals; descriptor ram holds no reset; no stall
`default_nettype none
module coalescing_chunk_table
   import cct_pkg::*;
#(
   parameter int SLOTS     = 32,
   parameter int ADDR_BITS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   output rsp_type         rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [5:0] csr_wr_data
);
   localparam int IW = $clog2(SLOTS);
   localparam int NW = IW + 1;
   localparam int DW = ADDR_BITS + 31;

   // configuration, clamped to slots
   logic [NW-1:0] n_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= NW'(SLOTS);
      end else if (csr_wr_en) begin
         if ({26'd0, csr_wr_data} > 32'(SLOTS)) n_ff <= NW'(SLOTS);
         else n_ff <= NW'(csr_wr_data);
      end
   end

   // per-slot flags
   logic [SLOTS-1:0] valid_ff, tag_ff;

   // descriptor ram: {start, length}
   logic            ram_we;
   logic [IW-1:0]   ram_addr;
   logic [DW-1:0]   ram_wd, ram_rd;
   cct_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd), .rd_data(ram_rd));
   logic [ADDR_BITS-1:0] rd_start;
   logic [30:0]          rd_len;
   assign rd_start = ram_rd[DW-1:31];
   assign rd_len   = ram_rd[30:0];

   state_type state_ff, state_in;
   logic [2:0]  op_ff;
   logic        id_ff;
   logic [ADDR_BITS-1:0] cs_ff, cs_in;
   logic [30:0] cl_ff, cl_in, req_ff;
   logic [IW-1:0] fcur_ff, fcur_in, dcur_ff, dcur_in;
   logic [31:0] ftot_ff, ftot_in, dtot_ff, dtot_in;
   logic [IW-1:0] j_ff, j_in;    // scan slot
   logic [NW-1:0] cnt_ff, cnt_in; // slots visited
   logic        ph_ff, ph_in;    // 0 issue read, 1 data back
   logic        seen_ff, seen_in;
   logic        chain_ff, chain_in; // merge pass is a give-back (prepend first)
   logic [IW-1:0] tj_ff, tj_in;  // slot taken
   logic [ADDR_BITS-1:0] gs_ff, gs_in;
   logic [30:0] gl_ff, gl_in;
   logic [31:0] lb_ff, lb_in;
   logic        full_ff, full_in;
   logic [SLOTS-1:0] valid_in, tag_in;

   logic [IW-1:0] cur_sel;
   logic          jv, jin, jblank;
   logic [IW-1:0] jnext;
   logic [31:0]   suml;
   logic          fit, pre_ok, app_ok;
   logic [ADDR_BITS-1:0] cs_end, sl_end;

   assign cur_sel = id_ff ? dcur_ff : fcur_ff;
   assign jv      = {1'b0, j_ff} < n_ff;
   assign jin     = valid_ff[j_ff] && tag_ff[j_ff] == id_ff;
   assign jblank  = !valid_ff[j_ff];
   assign jnext   = ({1'b0, j_ff} + 1'b1 >= n_ff) ? '0 : j_ff + 1'b1;
   assign suml    = {1'b0, rd_len} + {1'b0, cl_ff};
   assign fit     = suml <= {1'b0, MAX_LEN};
   assign cs_end  = cs_ff + ADDR_BITS'(cl_ff);
   assign sl_end  = rd_start + ADDR_BITS'(rd_len);
   assign pre_ok  = rd_start == cs_end && fit;
   assign app_ok  = sl_end == cs_ff && fit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         tag_ff   <= '0;
         fcur_ff  <= '0;
         dcur_ff  <= '0;
         ftot_ff  <= '0;
         dtot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         tag_ff   <= tag_in;
         fcur_ff  <= fcur_in;
         dcur_ff  <= dcur_in;
         ftot_ff  <= ftot_in;
         dtot_ff  <= dtot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         op_ff  <= req_data.opcode;
         id_ff  <= req_data.list_select;
         req_ff <= req_data.request_bytes;
      end
      cs_ff <= cs_in; cl_ff <= cl_in;
      j_ff <= j_in; cnt_ff <= cnt_in; ph_ff <= ph_in;
      seen_ff <= seen_in; chain_ff <= chain_in; tj_ff <= tj_in;
      gs_ff <= gs_in; gl_ff <= gl_in; lb_ff <= lb_in; full_ff <= full_in;
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff; tag_in = tag_ff;
      fcur_in = fcur_ff; dcur_in = dcur_ff; ftot_in = ftot_ff; dtot_in = dtot_ff;
      cs_in = cs_ff; cl_in = cl_ff; j_in = j_ff; cnt_in = cnt_ff; ph_in = ph_ff;
      seen_in = seen_ff; chain_in = chain_ff; tj_in = tj_ff;
      gs_in = gs_ff; gl_in = gl_ff; lb_in = lb_ff; full_in = full_ff;
      ram_we = 1'b0; ram_addr = j_ff; ram_wd = {rd_start, rd_len};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cs_in = ADDR_BITS'(req_data.chunk_start);
               cl_in = req_data.chunk_bytes;
               gs_in = '0; gl_in = '0; lb_in = '0; full_in = 1'b0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            ph_in = 1'b0; cnt_in = '0; seen_in = 1'b0;
            j_in = ({1'b0, cur_sel} < n_ff) ? cur_sel : '0;
            case (op_ff)
               OP_GET: begin
                  j_in = cur_sel;
                  state_in = ST_TAKE;
               end
               OP_UNGET, OP_PUT: begin
                  chain_in = op_ff == OP_UNGET;
                  if (id_ff) dtot_in = dtot_ff + {1'b0, cl_ff};
                  else ftot_in = ftot_ff + {1'b0, cl_ff};
                  state_in = ST_MERGE_SCAN;
               end
               OP_QUERY: begin
                  lb_in = id_ff ? dtot_ff : ftot_ff;
                  state_in = ST_DONE;
               end
               OP_CLEAR: begin
                  j_in = '0;
                  state_in = ST_CLEAR;
               end
               default: state_in = ST_DONE;
            endcase
         end
         // take from cursor slot; a get takes up to req bytes, a take inside coalescing takes the whole slot
         ST_TAKE: begin
            if (!ph_ff) begin
               if (!jv || !jin) begin
                  if (op_ff == OP_GET) begin
                     gs_in = '0; gl_in = '0;
                  end
                  state_in = ST_DONE;
               end else ph_in = 1'b1;
            end else begin
               tj_in = j_ff;
               if (op_ff == OP_GET) gs_in = rd_start;
               cs_in = rd_start;
               if (op_ff != OP_GET || rd_len <= req_ff) begin
                  cl_in = rd_len;
                  valid_in[j_ff] = 1'b0;
               end else begin
                  cl_in = req_ff;
                  ram_we = 1'b1;
                  ram_wd = {rd_start + ADDR_BITS'(req_ff), rd_len - req_ff};
               end
               if (op_ff == OP_GET) gl_in = (rd_len <= req_ff) ? rd_len : req_ff;
               ph_in = 1'b0; cnt_in = '0;
               state_in = ST_TAKE_SCAN;
            end
         end
         ST_TAKE_SCAN: begin
            // search starts at the taken slot; flags read directly
            if (cnt_ff >= n_ff) begin
               if (id_ff) dcur_in = '0; else fcur_in = '0;
               state_in = ST_TAKE_SCAN;
               cnt_in = '0;
               j_in = '0;
               if (id_ff) dtot_in = dtot_ff - {1'b0, cl_ff};
               else ftot_in = ftot_ff - {1'b0, cl_ff};
               if (op_ff == OP_GET) state_in = ST_DONE;
               else begin
                  chain_in = 1'b1;
                  ftot_in = ftot_ff;
                  j_in = '0;
                  state_in = ST_MERGE_SCAN;
               end
            end else if (cnt_ff == '0 && !({1'b0, tj_ff} < n_ff)) begin
               j_in = '0; cnt_in = cnt_ff + 1'b1;
            end else if (jin && jv) begin
               if (id_ff) dcur_in = j_ff; else fcur_in = j_ff;
               if (id_ff) dtot_in = dtot_ff - {1'b0, cl_ff};
               else ftot_in = ftot_ff - {1'b0, cl_ff};
               if (op_ff == OP_GET) state_in = ST_DONE;
               else begin
                  chain_in = 1'b1;
                  ftot_in = ftot_ff;
                  cnt_in = '0;
                  state_in = ST_MERGE_SCAN;
               end
            end else begin
               j_in = jnext; cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MERGE_SCAN: begin
            if (cnt_ff >= n_ff) begin
               ph_in = 1'b0; cnt_in = '0;
               j_in = ({1'b0, cur_sel} < n_ff) ? cur_sel : '0;
               state_in = ST_BLANK_SCAN;
            end else if (!ph_ff) begin
               if (jin) ph_in = 1'b1;
               else begin
                  j_in = jnext; cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               ph_in = 1'b0;
               // give-back prepends, put appends; the other side only on the free list
               if (chain_ff ? pre_ok || (!id_ff && app_ok) : app_ok || (!id_ff && pre_ok)) begin
                  ram_we = 1'b1;
                  if ((chain_ff || !app_ok) && pre_ok) ram_wd = {cs_ff, suml[30:0]};
                  else ram_wd = {rd_start, suml[30:0]};
                  if (id_ff) state_in = ST_DONE;
                  else begin
                     // coalesce: take whole free cursor slot, then give back
                     if (chain_ff) ftot_in = ftot_ff; // already counted
                     j_in = fcur_ff; cnt_in = '0;
                     state_in = ST_TAKE;
                  end
               end else begin
                  seen_in = 1'b1;
                  j_in = jnext; cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_BLANK_SCAN: begin
            if (cnt_ff >= n_ff) begin
               full_in = 1'b1;
               if (id_ff) dtot_in = dtot_ff - {1'b0, cl_ff};
               else ftot_in = ftot_ff - {1'b0, cl_ff};
               state_in = ST_DONE;
            end else if (jblank) begin
               valid_in[j_ff] = 1'b1; tag_in[j_ff] = id_ff;
               ram_we = 1'b1; ram_wd = {cs_ff, cl_ff};
               if (chain_ff || !seen_ff) begin
                  if (id_ff) dcur_in = j_ff; else fcur_in = j_ff;
               end
               state_in = ST_DONE;
            end else begin
               j_in = jnext; cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CLEAR: begin
            if ({1'b0, j_ff} < n_ff) begin
               valid_in[j_ff] = 1'b0; tag_in[j_ff] = 1'b0;
            end
            if (cnt_ff + 1'b1 >= NW'(SLOTS)) state_in = ST_DONE;
            j_in = j_ff + 1'b1; cnt_in = cnt_ff + 1'b1;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // a take inside coalescing leaves the free-list total unchanged
      if (state_ff == ST_TAKE_SCAN && op_ff != OP_GET && state_in == ST_MERGE_SCAN)
         ftot_in = ftot_ff;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_DONE;
   always_comb begin
      rsp_data.got_start  = 32'(gs_ff);
      rsp_data.got_bytes  = gl_ff;
      rsp_data.list_bytes = lb_ff;
      rsp_data.table_full = full_ff;
   end
endmodule
`default_nettype wire
